### sv/slbs_pkg.sv
package slbs_pkg;

  // Field widths
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned STEP_W   = 3;
  localparam int unsigned WAIT_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 1;

  // Default gap between pattern repeats, in ticks
  localparam int unsigned GAP_MS_DEF = 20;

  // Opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OFF   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ON    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT  = 2'd1;

  // Longest step duration in the pattern table
  localparam logic [WAIT_W-1:0] DUR_MAX = 11'd1500;

  typedef struct packed {
    logic                opcode;
    logic [STATUS_W-1:0] new_status;
    logic                force_req;
  } slbs_in_t;

  typedef struct packed {
    logic pin_level;
    logic pin_driven;
  } slbs_out_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [STEP_W-1:0]   step;
    logic [WAIT_W-1:0]   wait_cnt;
    logic                lit;
  } slbs_state_t;

  // Pattern table: step duration in ticks, zero ends the pattern
  function automatic logic [WAIT_W-1:0] pattern_dur(logic [STATUS_W-1:0] st,
                                                    logic [STEP_W-1:0] idx);
    logic [WAIT_W-1:0] dur;
    dur = '0;
    case (st)
      ST_OK: begin
        case (idx)
          3'd0:    dur = 11'd100;
          3'd1:    dur = 11'd900;
          default: dur = '0;
        endcase
      end
      ST_ERROR: begin
        case (idx)
          3'd0, 3'd1, 3'd2, 3'd3, 3'd4: dur = 11'd100;
          3'd5:    dur = 11'd1500;
          default: dur = '0;
        endcase
      end
      ST_ON: begin
        case (idx)
          3'd0:    dur = 11'd100;
          default: dur = '0;
        endcase
      end
      default: dur = '0;
    endcase
    return dur;
  endfunction

endpackage

### sv/status_led_blink_sequencer_core.sv
// Each input transfer writes its result into the output register.
// Throughput: one item per cycle; the input stalls only while a held result is stalled.
// State update and table lookup are one combinational step between the state and
// output registers.
// Reset (synchronous, rst_n low) clears status, step, countdown, lit, enabled and invert.
module status_led_blink_sequencer_core import slbs_pkg::*; #(
  parameter int unsigned GAP_MS = GAP_MS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  slbs_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output slbs_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        enabled_r;
  logic        invert_r;
  slbs_state_t state_r;
  slbs_state_t state_nxt;
  logic        out_valid_r;
  slbs_out_t   out_data_r;
  logic        in_xfer;

  // Accept while the output register is empty or draining
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  slbs_step #(
    .GAP_MS(GAP_MS)
  ) u_step (
    .cur  (state_r),
    .item (in_data),
    .nxt  (state_nxt)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      invert_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ENABLED: enabled_r <= cfg_wdata[0];
        CFG_INVERT:  invert_r  <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  // Advance sequencer state; hold it while disabled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_xfer && enabled_r) begin
      state_r <= state_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r.pin_level  <= enabled_r & (state_nxt.lit ^ invert_r);
      out_data_r.pin_driven <= enabled_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // An undriven pin never shows a high level
  a_level_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.pin_driven || !out_data_r.pin_level))
    else $error("pin_level high while pin not driven");

  // A disabled block keeps its sequencer state
  a_frozen_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !enabled_r) |=> $stable(state_r))
    else $error("state changed while disabled");

  // A forced set restarts the pattern from step zero with no wait
  a_force_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && enabled_r && in_data.opcode == OP_SET && in_data.force_req)
    |=> (state_r.step == '0 && state_r.wait_cnt == '0))
    else $error("forced set did not restart the pattern");

  // Step and countdown stay within the table
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.step <= 3'd6) && (state_r.wait_cnt <= DUR_MAX))
    else $error("step or countdown out of range");
`endif

endmodule

### sv/slbs_step.sv
module slbs_step import slbs_pkg::*; #(
  parameter int unsigned GAP_MS = GAP_MS_DEF
) (
  input  slbs_state_t cur,
  input  slbs_in_t    item,
  output slbs_state_t nxt
);

  logic [WAIT_W-1:0] wait_dec;
  logic [WAIT_W-1:0] dur;
  logic              wait_hold;

  // Count down; a step runs when the count is or reaches zero
  assign wait_dec  = cur.wait_cnt - 1'b1;
  assign wait_hold = (cur.wait_cnt != '0) && (wait_dec != '0);
  assign dur       = pattern_dur(cur.status, cur.step);

  always_comb begin
    nxt = cur;
    if (item.opcode == OP_SET) begin
      // Restart the pattern on a new status or a forced set
      if (item.force_req || (item.new_status != cur.status)) begin
        nxt.status   = item.new_status;
        nxt.step     = '0;
        nxt.wait_cnt = '0;
        nxt.lit      = (item.new_status == ST_ON);
      end
    end else if (wait_hold) begin
      nxt.wait_cnt = wait_dec;
    end else if (dur == '0) begin
      // End of pattern: wait out the gap, keep the level
      nxt.step     = '0;
      nxt.wait_cnt = WAIT_W'(GAP_MS);
    end else begin
      // Even steps light, odd steps darken
      nxt.lit      = ~cur.step[0];
      nxt.wait_cnt = dur;
      nxt.step     = cur.step + 1'b1;
    end
  end

endmodule

### verif/tb_status_led_blink_sequencer_core.sv
module tb_status_led_blink_sequencer_core;
  import slbs_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  slbs_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  slbs_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_ENABLED;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predicted pin state, oldest first
  slbs_out_t exp_pins[$];

  // Shadow copy of the sequencer state and registers
  logic [STATUS_W-1:0] m_status = ST_OFF;
  logic [STEP_W-1:0]   m_step = '0;
  logic [WAIT_W-1:0]   m_wait = '0;
  logic                m_lit = 1'b0;
  logic                m_en = 1'b0;
  logic                m_inv = 1'b0;

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          steady_flow = 1'b0;

  status_led_blink_sequencer_core #(
    .GAP_MS(GAP_MS_DEF)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Step durations in ticks; zero marks the end of a pattern
  function automatic logic [WAIT_W-1:0] step_ticks(logic [STATUS_W-1:0] st,
                                                   logic [STEP_W-1:0] idx);
    logic [WAIT_W-1:0] dur;
    case (st)
      ST_OK:    dur = (idx == 3'd0) ? 11'd100 : (idx == 3'd1) ? 11'd900 : 11'd0;
      ST_ERROR: dur = (idx < 3'd5) ? 11'd100 : (idx == 3'd5) ? 11'd1500 : 11'd0;
      ST_ON:    dur = (idx == 3'd0) ? 11'd100 : 11'd0;
      default:  dur = 11'd0;
    endcase
    return dur;
  endfunction

  // Advance the shadow state by one item and return the pin drive it leads to
  function automatic slbs_out_t led_model_step(slbs_in_t it);
    slbs_out_t         r;
    logic [WAIT_W-1:0] dur;
    logic              run_step;
    r = '0;
    if (m_en) begin
      if (it.opcode == OP_SET) begin
        if (it.force_req || it.new_status != m_status) begin
          m_status = it.new_status;
          m_step   = '0;
          m_wait   = '0;
          m_lit    = (it.new_status == ST_ON);
        end
      end else begin
        run_step = 1'b1;
        if (m_wait != '0) begin
          m_wait   = m_wait - 1'b1;
          run_step = (m_wait == '0);
        end
        if (run_step) begin
          dur = step_ticks(m_status, m_step);
          if (dur == '0) begin
            m_step = '0;
            m_wait = WAIT_W'(GAP_MS_DEF);
          end else begin
            m_lit  = ~m_step[0];
            m_wait = dur;
            m_step = m_step + 1'b1;
          end
        end
      end
      r.pin_level  = m_lit ^ m_inv;
      r.pin_driven = 1'b1;
    end
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // Check each output transfer against the oldest prediction
  always @(posedge clk) begin
    slbs_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_pins.size() == 0) begin
        note_mismatch($sformatf("unexpected result level=%0b driven=%0b",
                                out_data.pin_level, out_data.pin_driven));
      end else begin
        want = exp_pins.pop_front();
        if (out_data.pin_level !== want.pin_level)
          note_mismatch($sformatf("pin_level expected %0b got %0b",
                                  want.pin_level, out_data.pin_level));
        if (out_data.pin_driven !== want.pin_driven)
          note_mismatch($sformatf("pin_driven expected %0b got %0b",
                                  want.pin_driven, out_data.pin_driven));
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb_status_led_blink_sequencer_core: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive the result stall: long hold-off on request, none during steady flow, otherwise random
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (steady_flow) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 34);
    end
  end

  // Offer one item, wait for its transfer and record the prediction
  task automatic push_item(slbs_in_t it);
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < 34) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    exp_pins.push_back(led_model_step(it));
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has arrived
  task automatic drain();
    in_valid = 1'b0;
    while (exp_pins.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_ENABLED) m_en = val[0];
    else if (idx == CFG_INVERT) m_inv = val[0];
  endtask

  function automatic slbs_in_t make_item(logic op, logic [STATUS_W-1:0] st, logic frc);
    slbs_in_t it;
    it.opcode     = op;
    it.new_status = st;
    it.force_req  = frc;
    return it;
  endfunction

  // Random item; sets appear with the given rate per thousand
  function automatic slbs_in_t rand_item(int unsigned set_permille);
    logic op;
    op = ($urandom_range(0, 999) < set_permille) ? OP_SET : OP_TICK;
    return make_item(op, STATUS_W'($urandom), 1'($urandom));
  endfunction

  // Block out of reset is disabled: everything is ignored
  task automatic test_disabled_after_reset();
    push_item(make_item(OP_TICK, ST_ON, 1'b1));
    push_item(make_item(OP_SET, ST_ON, 1'b1));
    push_item(make_item(OP_SET, ST_ERROR, 1'b0));
    drain();
  endtask

  // Walk every status, force on and off, and ignored commands
  task automatic test_status_commands();
    write_reg(CFG_ENABLED, 1'b1);
    push_item(make_item(OP_TICK, ST_OFF, 1'b0));
    push_item(make_item(OP_SET, ST_OFF, 1'b0));
    push_item(make_item(OP_SET, ST_OFF, 1'b1));
    push_item(make_item(OP_SET, ST_ON, 1'b0));
    push_item(make_item(OP_SET, ST_ON, 1'b0));
    push_item(make_item(OP_TICK, ST_ERROR, 1'b1));
    push_item(make_item(OP_SET, ST_OK, 1'b0));
    push_item(make_item(OP_TICK, ST_ON, 1'b0));
    push_item(make_item(OP_TICK, ST_OFF, 1'b1));
    push_item(make_item(OP_SET, ST_ERROR, 1'b1));
    push_item(make_item(OP_TICK, ST_OK, 1'b0));
    push_item(make_item(OP_SET, ST_ERROR, 1'b1));
    push_item(make_item(OP_SET, ST_ON, 1'b1));
    drain();
  endtask

  // Flip the pin polarity with the LED both lit and dark
  task automatic test_invert();
    write_reg(CFG_INVERT, 1'b1);
    push_item(make_item(OP_TICK, ST_OFF, 1'b0));
    push_item(make_item(OP_SET, ST_OFF, 1'b1));
    push_item(make_item(OP_TICK, ST_ON, 1'b1));
    push_item(make_item(OP_SET, ST_ON, 1'b0));
    drain();
    write_reg(CFG_INVERT, 1'b0);
  endtask

  // Long tick runs with rare sets step through the patterns, then noise, a disabled run and a re-enabled one
  task automatic test_random_patterns();
    push_item(make_item(OP_SET, ST_ERROR, 1'b1));
    repeat (900) push_item(rand_item(2));
    drain();

    write_reg(CFG_INVERT, 1'b1);
    push_item(make_item(OP_SET, ST_OK, 1'b1));
    steady_flow = 1'b1;
    repeat (300) push_item(rand_item(2));
    steady_flow = 1'b0;
    repeat (400) push_item(rand_item(2));
    drain();

    write_reg(CFG_INVERT, 1'b0);
    repeat (300) push_item(rand_item(300));
    drain();

    write_reg(CFG_ENABLED, 1'b0);
    repeat (60) push_item(rand_item(500));
    drain();

    write_reg(CFG_ENABLED, 1'b1);
    write_reg(CFG_INVERT, 1'b1);
    repeat (40) push_item(rand_item(100));
    drain();
  endtask

  // Hold the result side off so the block fills and stalls its input
  task automatic test_backpressure();
    hold_left = HOLD_CYCLES;
    repeat (120) push_item(rand_item(50));
    drain();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_disabled_after_reset();
    test_status_commands();
    test_invert();
    test_random_patterns();
    test_backpressure();

    drain();
    if (exp_pins.size() != 0) note_mismatch("results still outstanding at end");
    if (mismatches == 0) begin
      $display("tb_status_led_blink_sequencer_core: PASS");
    end else begin
      $display("tb_status_led_blink_sequencer_core: FAIL");
    end
    $finish;
  end

endmodule
